// ===== hdl/ncas_pkg.sv =====
// Shared types and constants for the nearest-centroid assignment block.
// Used by ncas_cell and nearest_centroid_assign; depends on nothing else.
`default_nettype none

package ncas_pkg;

    localparam int MAX_CLUSTERS = 32;
    localparam int COORD_BITS   = 24;
    localparam int IDX_BITS     = 5;
    localparam int CNT_BITS     = 6;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int SQ_BITS      = 2 * COORD_BITS + 1;
    localparam int DIST_BITS    = SQ_BITS + 1;
    localparam int OUT_DIST_BITS = 49;

    localparam logic [CNT_BITS-1:0] ACTIVE_RESET = CNT_BITS'(20);

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // One item as it travels down the row of cells.
    typedef struct packed {
        logic                  valid;
        logic                  command;
        logic [IDX_BITS-1:0]   slot;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  eob;
        logic [IDX_BITS-1:0]   best_idx;
        logic [DIST_BITS-1:0]  best_dist;
    } item_t;

endpackage

`default_nettype wire

// ===== hdl/ncas_cell.sv =====
// One cell of the centroid row: holds one centroid and carries items through a
// three-stage difference / square / compare pipeline. Depends on ncas_pkg.
`default_nettype none

module ncas_cell
    import ncas_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic [IDX_BITS-1:0] cell_index,
    input  wire logic [CNT_BITS-1:0] active_clusters,
    input  wire item_t               item_in,
    output item_t                    item_out
);

    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;

    item_t                 s1_item_reg;
    logic [DIFF_BITS-1:0]  s1_dx_reg;
    logic [DIFF_BITS-1:0]  s1_dy_reg;
    item_t                 s2_item_reg;
    logic [SQ_BITS-1:0]    s2_sqx_reg;
    logic [SQ_BITS-1:0]    s2_sqy_reg;
    item_t                 s3_item_reg;

    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;

    logic                  load_hit;
    logic [DIFF_BITS-1:0]  dx_next;
    logic [DIFF_BITS-1:0]  dy_next;
    logic signed [2*DIFF_BITS-1:0] prod_x;
    logic signed [2*DIFF_BITS-1:0] prod_y;
    logic [DIST_BITS-1:0]  dist_sum;
    logic                  take;
    item_t                 s3_item_next;

    assign load_hit = item_in.valid && (item_in.command == CMD_LOAD)
                      && (item_in.slot == cell_index);

    // A load writes the centroid as it passes, so earlier items in the row
    // still see the old value and later ones the new value.
    always_ff @(posedge clk)
    begin
        if (advance && load_hit)
        begin
            cx_reg <= item_in.x;
            cy_reg <= item_in.y;
        end
    end

    assign dx_next = DIFF_BITS'($signed({item_in.x[COORD_BITS-1], item_in.x})
                                - $signed({cx_reg[COORD_BITS-1], cx_reg}));
    assign dy_next = DIFF_BITS'($signed({item_in.y[COORD_BITS-1], item_in.y})
                                - $signed({cy_reg[COORD_BITS-1], cy_reg}));

    assign prod_x = $signed(s1_dx_reg) * $signed(s1_dx_reg);
    assign prod_y = $signed(s1_dy_reg) * $signed(s1_dy_reg);

    assign dist_sum = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};

    // Entry zero always opens the search; later entries need a strictly
    // smaller distance so that the first of equal distances is kept.
    assign take = (s2_item_reg.command == CMD_CLASSIFY)
                  && ((cell_index == '0)
                      || (({1'b0, cell_index} < active_clusters)
                          && (dist_sum < s2_item_reg.best_dist)));

    always_comb
    begin
        s3_item_next = s2_item_reg;
        if (take)
        begin
            s3_item_next.best_dist = dist_sum;
            s3_item_next.best_idx  = cell_index;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg <= item_in;
            s1_dx_reg   <= dx_next;
            s1_dy_reg   <= dy_next;
            s2_item_reg <= s1_item_reg;
            s2_sqx_reg  <= prod_x[SQ_BITS-1:0];
            s2_sqy_reg  <= prod_y[SQ_BITS-1:0];
            s3_item_reg <= s3_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= item_in.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_comb
    begin
        item_out       = s3_item_reg;
        item_out.valid = s3_valid_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/nearest_centroid_assign.sv =====
// Top level of the nearest-centroid assignment block: a row of ncas_cell
// instances, the active-count register and the result register. Uses ncas_pkg.
`default_nettype none

// Takes one item per cycle unless the row is stalled: a load (tuser = 0)
// writes centroid `slot`, a classify (tuser = 1) returns the lowest-numbered
// entry among the first active_clusters entries (at least one, at most 32)
// with the smallest squared distance, and that distance. Items walk a row of 32
// cells, each holding one centroid and a difference / square / compare
// pipeline, and the result is registered after the last cell; loads and samples
// may be interleaved freely and each sample sees exactly the loads that came
// before it. When a classify reaches the end of the row while the result
// register is still held by the downstream side, the whole row stalls. Loads
// give no result. Write active_clusters only while no items are in flight.

module nearest_centroid_assign
    import ncas_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data,      // active_clusters

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,       // slot[4:0], coord_x[28:5], coord_y[52:29], zeros
    input  wire logic        s_tuser,       // command
    input  wire logic        s_tlast,       // end_of_batch

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,       // cluster_index[4:0], best_distance_sq[53:5], zeros
    output logic             m_tlast        // batch_done
);

    logic [CNT_BITS-1:0] active_reg;
    item_t               chain [MAX_CLUSTERS+1];
    item_t               tail;
    logic                tail_classify;
    logic                advance;

    logic                out_valid_reg, out_valid_next;
    logic [IDX_BITS-1:0] out_idx_reg;
    logic [OUT_DIST_BITS-1:0] out_dist_reg;
    logic                out_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= ACTIVE_RESET;
        else if (cfg_valid && cfg_ready)
            active_reg <= cfg_data;
    end

    assign tail          = chain[MAX_CLUSTERS];
    assign tail_classify = tail.valid && (tail.command == CMD_CLASSIFY);
    assign advance       = !out_valid_reg || m_tready || !tail_classify;
    assign s_tready      = advance;

    always_comb
    begin
        chain[0]           = '0;
        chain[0].valid     = s_tvalid;
        chain[0].command   = s_tuser;
        chain[0].slot      = s_tdata[IDX_BITS-1:0];
        chain[0].x         = s_tdata[28:5];
        chain[0].y         = s_tdata[52:29];
        chain[0].eob       = s_tlast;
    end

    for (genvar i = 0; i < MAX_CLUSTERS; i++)
    begin : g_cell
        ncas_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .advance         (advance),
            .cell_index      (IDX_BITS'(i)),
            .active_clusters (active_reg),
            .item_in         (chain[i]),
            .item_out        (chain[i+1])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && tail_classify)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail_classify)
        begin
            out_idx_reg  <= tail.best_idx;
            out_dist_reg <= tail.best_dist[OUT_DIST_BITS-1:0];
            out_last_reg <= tail.eob;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_dist_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

    // The row only stalls when a finished result is waiting downstream.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && tail_classify))
        else $error("input stalled without a blocked result");

    // A fresh result always comes from a classify leaving the row.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(tail_classify))
        else $error("result appeared without a classify item");

    // The winning entry lies within the active part of the table.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[4:0] == 5'd0) || ({1'b0, m_tdata[4:0]} < active_reg)))
        else $error("cluster index outside the active entries");

endmodule

`default_nettype wire
